[hdl/pid_speed_controller_defines.svh]
// ---------------------------------------------------------------------------
// pid_speed_controller_defines
// assertion macros for the speed controller top level
// ---------------------------------------------------------------------------
`ifndef PID_SPEED_CONTROLLER_DEFINES_SVH
`define PID_SPEED_CONTROLLER_DEFINES_SVH

`ifndef ASSERT_OFF
// checked outside reset
`define PSC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define PSC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PSC_ASSERT(label, clk, rst_n, prop, msg)
`define PSC_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

[hdl/psc_pkg.sv]
// ---------------------------------------------------------------------------
// psc_pkg
// types, widths, register indexes, action codes and reset values of the pid speed controller
// ---------------------------------------------------------------------------
package psc_pkg;

    localparam int DataW   = 16;
    localparam int TimeW   = 32;
    localparam int GainW   = 24;
    localparam int FracW   = 16;
    localparam int IntegW  = 33;
    localparam int CfgIdxW = 3;
    localparam int CfgDataW = 32;
    localparam int ActionW = 2;

    // action codes
    localparam logic [ActionW-1:0] ACT_SAMPLE  = 2'd0;
    localparam logic [ActionW-1:0] ACT_ENABLE  = 2'd1;
    localparam logic [ActionW-1:0] ACT_DISABLE = 2'd2;

    // register indexes
    localparam logic [CfgIdxW-1:0] REG_PROP_GAIN     = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_INTEG_GAIN    = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_DERIV_GAIN    = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_SAMPLE_PERIOD = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_OUT_MIN       = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_OUT_MAX       = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_REVERSE       = 3'd6;

    // reset values
    localparam logic [TimeW-1:0]        RST_SAMPLE_PERIOD = 32'd100000;
    localparam logic signed [DataW-1:0] RST_OUT_MIN       = 16'sd0;
    localparam logic signed [DataW-1:0] RST_OUT_MAX       = 16'sd255;

    typedef struct packed {
        logic [GainW-1:0]        prop_gain;
        logic [GainW-1:0]        integ_gain;
        logic [GainW-1:0]        deriv_gain;
        logic [TimeW-1:0]        sample_period_us;
        logic signed [DataW-1:0] out_min;
        logic signed [DataW-1:0] out_max;
        logic                    reverse;
    } cfg_t;

    // limits as they stand after a limit write, with a load strobe
    typedef struct packed {
        logic                    load;
        logic signed [DataW-1:0] out_min;
        logic signed [DataW-1:0] out_max;
    } lim_upd_t;

endpackage

[hdl/psc_regs.sv]
// ---------------------------------------------------------------------------
// psc_regs
// configuration register file with limit-change notification
// ---------------------------------------------------------------------------
module psc_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [psc_pkg::CfgIdxW-1:0]     cfg_index,
    input  logic [psc_pkg::CfgDataW-1:0]    cfg_data,
    output psc_pkg::cfg_t                   cfg,
    output psc_pkg::lim_upd_t               lim
);
    import psc_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prop_gain        <= '0;
            cfg_reg.integ_gain       <= '0;
            cfg_reg.deriv_gain       <= '0;
            cfg_reg.sample_period_us <= RST_SAMPLE_PERIOD;
            cfg_reg.out_min          <= RST_OUT_MIN;
            cfg_reg.out_max          <= RST_OUT_MAX;
            cfg_reg.reverse          <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PROP_GAIN:     cfg_reg.prop_gain        <= cfg_data[GainW-1:0];
                REG_INTEG_GAIN:    cfg_reg.integ_gain       <= cfg_data[GainW-1:0];
                REG_DERIV_GAIN:    cfg_reg.deriv_gain       <= cfg_data[GainW-1:0];
                REG_SAMPLE_PERIOD: cfg_reg.sample_period_us <= cfg_data[TimeW-1:0];
                REG_OUT_MIN:       cfg_reg.out_min          <= cfg_data[DataW-1:0];
                REG_OUT_MAX:       cfg_reg.out_max          <= cfg_data[DataW-1:0];
                REG_REVERSE:       cfg_reg.reverse          <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    assign cfg = cfg_reg;

    // new limit pair seen by the core in the cycle of the write
    always_comb
    begin
        lim.load    = cfg_we && ((cfg_index == REG_OUT_MIN) || (cfg_index == REG_OUT_MAX));
        lim.out_min = (cfg_index == REG_OUT_MIN) ? cfg_data[DataW-1:0] : cfg_reg.out_min;
        lim.out_max = (cfg_index == REG_OUT_MAX) ? cfg_data[DataW-1:0] : cfg_reg.out_max;
    end

endmodule

[hdl/psc_core.sv]
// ---------------------------------------------------------------------------
// psc_core
// controller state and the single-pass pid update
// ---------------------------------------------------------------------------
module psc_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                fire,
    input  logic [psc_pkg::ActionW-1:0]         action,
    input  logic [psc_pkg::TimeW-1:0]           now_us,
    input  logic signed [psc_pkg::DataW-1:0]    measured,
    input  logic signed [psc_pkg::DataW-1:0]    target,
    input  psc_pkg::cfg_t                       cfg,
    input  psc_pkg::lim_upd_t                   lim,
    output logic signed [psc_pkg::DataW-1:0]    drive,
    output logic                                updated,
    output logic                                active
);
    import psc_pkg::*;

    localparam int ErrW  = DataW + 1;
    localparam int KW    = GainW + 1;
    localparam int ProdW = KW + ErrW;
    localparam int SumW  = ProdW + 2;

    // clamp a q.16 value, upper limit tested first
    function automatic logic signed [SumW-1:0] clamp_q(
        input logic signed [SumW-1:0]  v,
        input logic signed [DataW-1:0] lo,
        input logic signed [DataW-1:0] hi
    );
        logic signed [SumW-1:0] lo_q;
        logic signed [SumW-1:0] hi_q;
        lo_q = {{(SumW-DataW-FracW){lo[DataW-1]}}, lo, {FracW{1'b0}}};
        hi_q = {{(SumW-DataW-FracW){hi[DataW-1]}}, hi, {FracW{1'b0}}};
        if (v > hi_q)
            return hi_q;
        else if (v < lo_q)
            return lo_q;
        else
            return v;
    endfunction

    logic                     enabled_reg, enabled_next;
    logic                     primed_reg, primed_next;
    logic signed [IntegW-1:0] integ_reg, integ_next;
    logic signed [DataW-1:0]  prev_meas_reg, prev_meas_next;
    logic [TimeW-1:0]         last_us_reg, last_us_next;
    logic signed [DataW-1:0]  drive_reg, drive_next;

    logic signed [KW-1:0]     kp, ki, kd;
    logic signed [ErrW-1:0]   err, dm;
    logic signed [ProdW-1:0]  p_prop, p_integ, p_deriv;
    logic signed [SumW-1:0]   integ_upd, drive_q, drive_ext_q;
    logic [TimeW-1:0]         elapsed;
    logic                     go;

    // signed gains
    always_comb
    begin
        kp = $signed({1'b0, cfg.prop_gain});
        ki = $signed({1'b0, cfg.integ_gain});
        kd = $signed({1'b0, cfg.deriv_gain});
        if (cfg.reverse)
        begin
            kp = -kp;
            ki = -ki;
            kd = -kd;
        end
    end

    assign err = ErrW'(target) - ErrW'(measured);
    assign dm  = ErrW'(measured) - ErrW'(prev_meas_reg);

    assign p_prop  = kp * err;
    assign p_integ = ki * err;
    assign p_deriv = kd * dm;

    assign integ_upd = clamp_q(SumW'(integ_reg) + SumW'(p_integ), cfg.out_min, cfg.out_max);
    assign drive_q   = clamp_q(SumW'(p_prop) + integ_upd - SumW'(p_deriv),
                               cfg.out_min, cfg.out_max);

    // held drive as q.16, for the bumpless load
    assign drive_ext_q = clamp_q({{(SumW-DataW-FracW){drive_reg[DataW-1]}}, drive_reg,
                                  {FracW{1'b0}}}, cfg.out_min, cfg.out_max);

    assign elapsed = now_us - last_us_reg;
    assign go = fire && (action == ACT_SAMPLE) && enabled_reg &&
                (!primed_reg || (elapsed >= cfg.sample_period_us));

    always_comb
    begin
        enabled_next   = enabled_reg;
        primed_next    = primed_reg;
        integ_next     = integ_reg;
        prev_meas_next = prev_meas_reg;
        last_us_next   = last_us_reg;
        drive_next     = drive_reg;
        unique case (action)
            ACT_SAMPLE:
            begin
                if (go)
                begin
                    integ_next     = integ_upd[IntegW-1:0];
                    drive_next     = drive_q[FracW +: DataW];
                    prev_meas_next = measured;
                    last_us_next   = now_us;
                    primed_next    = 1'b1;
                end
            end
            ACT_ENABLE:
            begin
                if (!enabled_reg)
                begin
                    integ_next     = drive_ext_q[IntegW-1:0];
                    prev_meas_next = measured;
                    enabled_next   = 1'b1;
                end
            end
            ACT_DISABLE:
                enabled_next = 1'b0;
            default:
                ;
        endcase
    end

    // limit-write clamp, as seen with the new limits
    logic signed [SumW-1:0] lim_drive_q, lim_integ_q;

    assign lim_drive_q = clamp_q({{(SumW-DataW-FracW){drive_reg[DataW-1]}}, drive_reg,
                                  {FracW{1'b0}}}, lim.out_min, lim.out_max);
    assign lim_integ_q = clamp_q(SumW'(integ_reg), lim.out_min, lim.out_max);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg   <= 1'b0;
            primed_reg    <= 1'b0;
            integ_reg     <= '0;
            prev_meas_reg <= '0;
            last_us_reg   <= '0;
            drive_reg     <= '0;
        end
        else if (lim.load)
        begin
            if (enabled_reg)
            begin
                drive_reg <= lim_drive_q[FracW +: DataW];
                integ_reg <= lim_integ_q[IntegW-1:0];
            end
        end
        else if (fire)
        begin
            enabled_reg   <= enabled_next;
            primed_reg    <= primed_next;
            integ_reg     <= integ_next;
            prev_meas_reg <= prev_meas_next;
            last_us_reg   <= last_us_next;
            drive_reg     <= drive_next;
        end
    end

    assign drive   = drive_next;
    assign updated = go;
    assign active  = enabled_next;

endmodule

[hdl/pid_speed_controller.sv]
// ---------------------------------------------------------------------------
// pid_speed_controller
// discrete pid speed controller, derivative on measurement, q8.16 gains
// ---------------------------------------------------------------------------
//  channel   dir  handshake                 payload
//  s_axis    in   s_axis_tvalid/tready      tdata now_us,measured,target; tuser action
//  m_axis    out  m_axis_tvalid/tready      tdata drive; tuser updated,active
//  cfg       in   cfg_we                    cfg_index, cfg_data (32 bit)
//
//  one item per cycle sustained unless the result side stalls; the full pid update
//  (three 25x17 multiplies, integrator clamp, drive sum and clamp) sits between
//  the input register and the result register, so the result register loads
//  when the held item is processed and the result is then offered on m_axis
//  reset clears the controller state and loads the register defaults
//  a stalled result holds in the result register; the input register takes
//  one more item, and s_axis_tready drops only when both are occupied
// ---------------------------------------------------------------------------
`include "pid_speed_controller_defines.svh"

module pid_speed_controller (
    input  logic                            clk,
    input  logic                            rst_n,
    // input stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [63:0]                     s_axis_tdata,  // now_us[31:0], measured[47:32], target[63:48]
    input  logic [psc_pkg::ActionW-1:0]     s_axis_tuser,  // action[1:0]
    // result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [psc_pkg::DataW-1:0]       m_axis_tdata,  // drive[15:0]
    output logic [1:0]                      m_axis_tuser,  // updated[0], active[1]
    // configuration
    input  logic                            cfg_we,
    input  logic [psc_pkg::CfgIdxW-1:0]     cfg_index,
    input  logic [psc_pkg::CfgDataW-1:0]    cfg_data
);
    import psc_pkg::*;

    // input register
    logic                     in_valid_reg;
    logic [ActionW-1:0]       action_reg;
    logic [TimeW-1:0]         now_reg;
    logic signed [DataW-1:0]  meas_reg;
    logic signed [DataW-1:0]  tgt_reg;

    // result register
    logic                     out_valid_reg;
    logic signed [DataW-1:0]  drive_out_reg;
    logic                     upd_out_reg;
    logic                     act_out_reg;

    logic                     fire;
    logic                     in_accept;

    cfg_t                     cfg;
    lim_upd_t                 lim;
    logic signed [DataW-1:0]  core_drive;
    logic                     core_updated;
    logic                     core_active;

    // the held item is processed when the result slot is free or draining
    assign fire          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || fire;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            action_reg <= s_axis_tuser;
            now_reg    <= s_axis_tdata[31:0];
            meas_reg   <= s_axis_tdata[47:32];
            tgt_reg    <= s_axis_tdata[63:48];
        end
    end

    psc_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .lim       (lim)
    );

    psc_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .action   (action_reg),
        .now_us   (now_reg),
        .measured (meas_reg),
        .target   (tgt_reg),
        .cfg      (cfg),
        .lim      (lim),
        .drive    (core_drive),
        .updated  (core_updated),
        .active   (core_active)
    );

    // result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fire)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            drive_out_reg <= core_drive;
            upd_out_reg   <= core_updated;
            act_out_reg   <= core_active;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = drive_out_reg;
    assign m_axis_tuser  = {act_out_reg, upd_out_reg};

    // a fresh drive only comes from an enabled controller
    `PSC_ASSERT(a_upd_needs_active, clk, rst_n, m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tuser[1], "updated result without active")

    // a processed item always lands in the result register
    `PSC_ASSERT(a_fire_fills_out, clk, rst_n, fire |=> out_valid_reg, "processed item lost")

    // back-pressure only when an item is waiting in the input register
    `PSC_ASSERT_ALWAYS(a_ready_low_held, clk, !s_axis_tready |-> in_valid_reg, "input stalled while empty")

    // a computed drive stays inside ordered limits
    `PSC_ASSERT(a_drive_in_limits, clk, rst_n, m_axis_tvalid && m_axis_tuser[0] && (cfg.out_min <= cfg.out_max) |-> (drive_out_reg >= cfg.out_min) && (drive_out_reg <= cfg.out_max), "drive outside limits")

endmodule

[tb/sv/psc_tb_pkg.sv]
// ---------------------------------------------------------------------------
// psc_tb_pkg
// drive predictor and result scoreboard for the pid speed controller bench
// ---------------------------------------------------------------------------
package psc_tb_pkg;

    import psc_pkg::*;

    typedef struct packed {
        logic signed [DataW-1:0] drive;
        logic                    updated;
        logic                    active;
    } drive_word_t;

    class drive_scoreboard;

        // register copy
        logic [GainW-1:0]        prop_gain;
        logic [GainW-1:0]        integ_gain;
        logic [GainW-1:0]        deriv_gain;
        logic [TimeW-1:0]        period_us;
        logic signed [DataW-1:0] lim_lo;
        logic signed [DataW-1:0] lim_hi;
        logic                    reverse_dir;

        // controller state, integrator in q.16
        logic                    on;
        logic                    primed;
        longint                  integ_q;
        logic signed [DataW-1:0] last_meas;
        logic [TimeW-1:0]        last_us;
        logic signed [DataW-1:0] drive_now;

        drive_word_t expected_drives[$];
        int          mismatches;

        function new();
            prop_gain   = '0;
            integ_gain  = '0;
            deriv_gain  = '0;
            period_us   = RST_SAMPLE_PERIOD;
            lim_lo      = RST_OUT_MIN;
            lim_hi      = RST_OUT_MAX;
            reverse_dir = 1'b0;
            on          = 1'b0;
            primed      = 1'b0;
            integ_q     = 0;
            last_meas   = '0;
            last_us     = '0;
            drive_now   = '0;
            mismatches  = 0;
        endfunction

        // upper limit is tested first, so inverted limits resolve as the rtl does
        function longint clamp_q16(longint v);
            longint hi_q;
            longint lo_q;
            hi_q = longint'(lim_hi) <<< FracW;
            lo_q = longint'(lim_lo) <<< FracW;
            if (v > hi_q) return hi_q;
            if (v < lo_q) return lo_q;
            return v;
        endfunction

        function logic signed [DataW-1:0] clamp_int(logic signed [DataW-1:0] v);
            if (v > lim_hi) return lim_hi;
            if (v < lim_lo) return lim_lo;
            return v;
        endfunction

        function void apply_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
            case (idx)
                REG_PROP_GAIN:     prop_gain   = data[GainW-1:0];
                REG_INTEG_GAIN:    integ_gain  = data[GainW-1:0];
                REG_DERIV_GAIN:    deriv_gain  = data[GainW-1:0];
                REG_SAMPLE_PERIOD: period_us   = data[TimeW-1:0];
                REG_OUT_MIN, REG_OUT_MAX:
                begin
                    if (idx == REG_OUT_MIN)
                        lim_lo = data[DataW-1:0];
                    else
                        lim_hi = data[DataW-1:0];
                    // new limits pull the running drive and integrator in
                    if (on)
                    begin
                        drive_now = clamp_int(drive_now);
                        integ_q   = clamp_q16(integ_q);
                    end
                end
                REG_REVERSE:       reverse_dir = data[0];
                default: ;
            endcase
        endfunction

        // note an accepted word and queue the result it causes
        function void predict_word(logic [ActionW-1:0] act, logic [TimeW-1:0] now_us,
                                   logic signed [DataW-1:0] meas,
                                   logic signed [DataW-1:0] tgt);
            longint           kp;
            longint           ki;
            longint           kd;
            longint           err;
            longint           dm;
            longint           sum;
            logic [TimeW-1:0] elapsed;
            bit               upd;
            upd     = 1'b0;
            elapsed = now_us - last_us;
            case (act)
                ACT_SAMPLE:
                begin
                    if (on && (!primed || elapsed >= period_us))
                    begin
                        kp = longint'(prop_gain);
                        ki = longint'(integ_gain);
                        kd = longint'(deriv_gain);
                        if (reverse_dir)
                        begin
                            kp = -kp;
                            ki = -ki;
                            kd = -kd;
                        end
                        err       = longint'(tgt) - longint'(meas);
                        dm        = longint'(meas) - longint'(last_meas);
                        integ_q   = clamp_q16(integ_q + ki * err);
                        sum       = clamp_q16(kp * err + integ_q - kd * dm);
                        drive_now = DataW'(sum >>> FracW);
                        last_meas = meas;
                        last_us   = now_us;
                        primed    = 1'b1;
                        upd       = 1'b1;
                    end
                end
                ACT_ENABLE:
                begin
                    if (!on)
                    begin
                        integ_q   = clamp_q16(longint'(drive_now) <<< FracW);
                        last_meas = meas;
                        on        = 1'b1;
                    end
                end
                ACT_DISABLE: on = 1'b0;
                default: ;
            endcase
            expected_drives.push_back(drive_word_t'{drive: drive_now, updated: upd, active: on});
        endfunction

        function int words_pending();
            return expected_drives.size();
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            $display("%0t mismatch: %s", $time, msg);
        endtask

        task check_word(logic signed [DataW-1:0] drive, logic updated, logic active);
            drive_word_t want;
            if (expected_drives.size() == 0)
            begin
                report_mismatch($sformatf("result word drive %0d with nothing expected", drive));
                return;
            end
            want = expected_drives.pop_front();
            if (drive !== want.drive)
                report_mismatch($sformatf("drive %0d, expected %0d", drive, want.drive));
            if (updated !== want.updated)
                report_mismatch($sformatf("updated %b, expected %b", updated, want.updated));
            if (active !== want.active)
                report_mismatch($sformatf("active %b, expected %b", active, want.active));
        endtask

    endclass

endpackage

[tb/sv/pid_speed_controller_tb.sv]
// ---------------------------------------------------------------------------
// pid_speed_controller_tb
// self-checking bench: directed corner words, then random control-loop phases
// with random idle on both streams; every result word is compared against a
// bit-exact fixed-point model of the controller
// ---------------------------------------------------------------------------
module pid_speed_controller_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import psc_pkg::*;
    import psc_tb_pkg::*;

    localparam int ClkPeriodNs   = 12;
    localparam int ResetCycles   = 6;
    localparam int MaxGap        = 18;
    localparam int HoldOffCycles = 400;
    localparam int DrainCycles   = 16;
    localparam int WordTarget    = 1600;

    // the one action code the block does not define
    localparam logic [ActionW-1:0] ACT_UNUSED = 2'd3;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [63:0]           s_axis_tdata  = '0;   // now_us[31:0], measured[47:32], target[63:48]
    logic [ActionW-1:0]    s_axis_tuser  = ACT_SAMPLE;  // action[1:0]
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [DataW-1:0]      m_axis_tdata;         // drive[15:0]
    logic [1:0]            m_axis_tuser;         // updated[0], active[1]
    logic                  cfg_we        = 1'b0;
    logic [CfgIdxW-1:0]    cfg_index     = REG_PROP_GAIN;
    logic [CfgDataW-1:0]   cfg_data      = '0;

    drive_scoreboard         drive_sb;
    int                      sent_words;
    bit                      rush;          // both sides run without idle
    bit                      hold_off_due;  // receiver owes one long stall
    logic [TimeW-1:0]        clock_us;      // running timestamp of the stimulus
    logic signed [DataW-1:0] meas_walk;     // slowly drifting measurement

    pid_speed_controller dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #(ClkPeriodNs / 2) clk = ~clk;

    // idle cycles before the next word on either side
    function automatic int draw_gap();
        if (rush)
            return 0;
        return $urandom_range(0, MaxGap);
    endfunction

    // offer one word from a falling edge, hold it until taken; valid stays
    // high straight into the next word when no gap is drawn
    task automatic send_word(input logic [ActionW-1:0] act, input logic [TimeW-1:0] now_us,
                             input logic signed [DataW-1:0] meas,
                             input logic signed [DataW-1:0] tgt);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {tgt, meas, now_us};
        s_axis_tuser  = act;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        drive_sb.predict_word(act, now_us, meas, tgt);
        sent_words++;
        @(negedge clk);
    endtask

    // every word causes exactly one result, so an empty store means idle;
    // the wait after it covers the two-stage pipe
    task automatic wait_idle();
        s_axis_tvalid = 1'b0;
        while (drive_sb.words_pending() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge clk);
        drive_sb.apply_reg(idx, data);
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // mostly gentle gains so the loop stays inside its limits, some extremes
    function automatic logic [CfgDataW-1:0] pick_gain();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 32'h00FF_FFFF;
            2, 3:    return $urandom;
            4, 5, 6: return $urandom_range(0, 32'h1000);
            default: return $urandom_range(0, 32'h2_0000);
        endcase
    endfunction

    function automatic logic [CfgDataW-1:0] pick_period();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 32'd1;
            2:       return $urandom;
            3:       return RST_SAMPLE_PERIOD;
            4, 5:    return $urandom_range(2, 20);
            default: return $urandom_range(21, 5000);
        endcase
    endfunction

    // next timestamp step, scaled to the sample period so updates keep coming
    function automatic logic [TimeW-1:0] next_step();
        logic [TimeW-1:0] span;
        span = (drive_sb.period_us > 32'h7FFF_FFFF) ? 32'hFFFF_FFFF
                                                    : (drive_sb.period_us << 1);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return drive_sb.period_us;
            2:       return $urandom;
            default: return $urandom_range(0, span);
        endcase
    endfunction

    // rewrite a random subset of the registers, or all of them
    task automatic shuffle_regs(input bit all_regs);
        logic signed [DataW-1:0] lo;
        logic signed [DataW-1:0] hi;
        logic signed [DataW-1:0] swap;
        if (all_regs || $urandom_range(0, 1))
            cfg_write(REG_PROP_GAIN, pick_gain());
        if (all_regs || $urandom_range(0, 1))
            cfg_write(REG_INTEG_GAIN, pick_gain());
        if (all_regs || $urandom_range(0, 1))
            cfg_write(REG_DERIV_GAIN, pick_gain());
        if (all_regs || $urandom_range(0, 1))
            cfg_write(REG_SAMPLE_PERIOD, pick_period());
        if (all_regs || $urandom_range(0, 1))
        begin
            lo = 16'($urandom);
            hi = 16'($urandom);
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    lo = 16'sh8000;
                    hi = 16'sh7FFF;
                end
                2: ;    // left unordered on purpose: inverted limits
                3:  hi = lo + 16'($urandom_range(0, 10));
                default:
                begin
                    if (lo > hi)
                    begin
                        swap = lo;
                        lo   = hi;
                        hi   = swap;
                    end
                end
            endcase
            // upper data bits carry junk, only the low half is a limit
            cfg_write(REG_OUT_MIN, {16'($urandom), lo});
            cfg_write(REG_OUT_MAX, {16'($urandom), hi});
        end
        if (all_regs || $urandom_range(0, 1))
            cfg_write(REG_REVERSE, $urandom);
    endtask

    // one control-loop phase: enable, then a run of mostly sample words
    task automatic run_phase(input int count);
        logic signed [DataW-1:0] tgt_set;
        logic signed [DataW-1:0] tgt;
        logic [ActionW-1:0]      act;
        int                      r;
        if ($urandom_range(0, 1))
            tgt_set = 16'($urandom);
        else
            tgt_set = 16'($urandom_range(0, 4000)) - 16'sd2000;
        send_word(ACT_ENABLE, clock_us, meas_walk, tgt_set);
        repeat (count)
        begin
            r = $urandom_range(0, 99);
            if (r < 86)
                act = ACT_SAMPLE;
            else if (r < 92)
                act = ACT_ENABLE;
            else if (r < 97)
                act = ACT_DISABLE;
            else
                act = ACT_UNUSED;
            clock_us = clock_us + next_step();
            if ($urandom_range(0, 3) == 0)
                meas_walk = 16'($urandom);
            else
                meas_walk = meas_walk + 16'($urandom_range(0, 400)) - 16'sd200;
            tgt = ($urandom_range(0, 9) == 0) ? 16'($urandom) : tgt_set;
            send_word(act, clock_us, meas_walk, tgt);
        end
    endtask

    // ------------------------------------------------------------------
    // result side: random ready, one long hold-off when asked for
    // ------------------------------------------------------------------
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            gap = draw_gap();
            if (hold_off_due)
            begin
                hold_off_due = 1'b0;
                gap          = HoldOffCycles;
            end
            if (gap > 0)
            begin
                m_axis_tready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_axis_tready = 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
            drive_sb.check_word(m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1]);
            @(negedge clk);
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial
    begin
        int phase;
        drive_sb     = new();
        sent_words   = 0;
        rush         = 1'b0;
        hold_off_due = 1'b0;
        clock_us     = '0;
        meas_walk    = '0;
        repeat (ResetCycles) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset defaults: zero gains, 100 ms period, limits 0..255
        send_word(ACT_SAMPLE, 32'd0, 16'sd10, 16'sd20);          // disabled, nothing moves
        send_word(ACT_UNUSED, 32'hFFFF_FFFF, -16'sd1, -16'sd1);  // undefined code ignored
        send_word(ACT_ENABLE, 32'd0, 16'sd100, 16'sd0);          // bumpless enable
        send_word(ACT_ENABLE, 32'd0, -16'sd100, 16'sd0);         // already on, no reload
        send_word(ACT_SAMPLE, 32'd5, 16'sd100, 16'sd200);        // first update fires at once
        send_word(ACT_SAMPLE, 32'd100_004, 16'sd90, 16'sd200);   // one microsecond short
        send_word(ACT_SAMPLE, 32'd100_005, 16'sd90, 16'sd200);   // exactly one period
        send_word(ACT_DISABLE, 32'd100_010, 16'sd0, 16'sd0);
        send_word(ACT_SAMPLE, 32'd300_000, 16'sd0, 16'sd0);      // frozen drive

        // unit proportional gain, smaller integral and derivative gains, zero period, full-range limits
        wait_idle();
        cfg_write(REG_PROP_GAIN, 32'h0001_0000);
        cfg_write(REG_INTEG_GAIN, 32'h0000_8000);
        cfg_write(REG_DERIV_GAIN, 32'h0000_4000);
        cfg_write(REG_SAMPLE_PERIOD, 32'd0);
        cfg_write(REG_OUT_MIN, 32'h0000_8000);
        cfg_write(REG_OUT_MAX, 32'h0000_7FFF);
        cfg_write(REG_REVERSE, 32'd0);
        send_word(ACT_ENABLE, 32'd300_000, 16'sd0, 16'sd0);
        send_word(ACT_SAMPLE, 32'd300_000, 16'sh8000, 16'sh7FFF); // error at its largest
        send_word(ACT_SAMPLE, 32'd300_000, 16'sh7FFF, 16'sh8000); // same stamp, zero period
        send_word(ACT_SAMPLE, 32'd0, 16'sd0, 16'sd0);

        // reverse acting, largest gains, largest period
        wait_idle();
        cfg_write(REG_REVERSE, 32'd1);
        cfg_write(REG_PROP_GAIN, 32'h00FF_FFFF);
        cfg_write(REG_INTEG_GAIN, 32'h00FF_FFFF);
        cfg_write(REG_DERIV_GAIN, 32'h00FF_FFFF);
        cfg_write(REG_SAMPLE_PERIOD, 32'hFFFF_FFFF);
        send_word(ACT_SAMPLE, 32'hFFFF_FFFF, 16'sd1000, -16'sd1000);
        send_word(ACT_SAMPLE, 32'd0, 16'sd1000, -16'sd1000);     // one tick later, gated

        // limits moved while enabled, then inverted; timestamp wraps
        wait_idle();
        cfg_write(REG_REVERSE, 32'd0);
        cfg_write(REG_PROP_GAIN, 32'h0002_0000);
        cfg_write(REG_INTEG_GAIN, 32'h0000_1000);
        cfg_write(REG_DERIV_GAIN, 32'h0000_0800);
        cfg_write(REG_SAMPLE_PERIOD, 32'd1000);
        cfg_write(REG_OUT_MIN, 32'd100);
        cfg_write(REG_OUT_MAX, 32'h0000_FF9C);                   // -100, below the minimum
        send_word(ACT_SAMPLE, 32'hFFFF_FF00, 16'sd50, 16'sd60);
        send_word(ACT_SAMPLE, 32'h0000_02E8, 16'sd55, 16'sd60);  // wrapped, exactly one period
        send_word(ACT_SAMPLE, 32'h0000_02E9, 16'sd55, 16'sd60);

        // sane limits again, then a disable/enable round trip
        wait_idle();
        cfg_write(REG_OUT_MIN, 32'h0000_FC18);                   // -1000
        cfg_write(REG_OUT_MAX, 32'd1000);
        send_word(ACT_DISABLE, 32'h0000_0300, 16'sd0, 16'sd0);
        send_word(ACT_ENABLE, 32'h0000_0300, 16'sd7, 16'sd0);
        send_word(ACT_SAMPLE, 32'h0000_1000, 16'sd7, 16'sd30);

        // random phases until enough words have been sent
        clock_us = 32'h0000_1000;
        phase    = 0;
        while (sent_words < WordTarget)
        begin
            wait_idle();
            shuffle_regs(phase == 0);
            rush = ($urandom_range(0, 3) == 0);
            // two phases where the result side stops long enough to back up input
            if (phase == 2 || phase == 9)
            begin
                rush         = 1'b1;
                hold_off_due = 1'b1;
            end
            run_phase($urandom_range(40, 120));
            phase++;
        end

        // drain
        s_axis_tvalid = 1'b0;
        rush          = 1'b0;
        while (drive_sb.words_pending() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
        if (drive_sb.mismatches == 0)
            $display("pid_speed_controller verification clean");
        else
            $display("pid_speed_controller verification failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #10ms;
        $display("pid_speed_controller verification failed");
        $finish;
    end

endmodule
